/* rtl/sdb_pkg.sv */
package sdb_pkg;

    localparam logic [31:0] CAPACITY_RESET = 32'd0;

    typedef enum logic [6:0] {
        ST_IDLE  = 7'b0000001,
        ST_LOAD  = 7'b0000010,
        ST_ROUND = 7'b0000100,
        ST_ADD   = 7'b0001000,
        ST_PAD   = 7'b0010000,
        ST_DIV   = 7'b0100000,
        ST_EMIT  = 7'b1000000
    } sdb_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take_byte;    // store a message byte and count it
        logic load_work;    // copy chain value into working registers
        logic do_round;     // run one compression round
        logic add_chain;    // fold working registers into chain value
        logic pad_byte;     // write one padding byte at the current position
        logic div_start;    // begin bucket reduction
        logic div_step;     // one restoring division step
        logic emit_shift;   // rotate the chain value toward the output
        logic restart;      // return to initial value
    } sdb_cmd_t;

    typedef struct packed {
        logic       pos_wrap;      // next write fills the block
        logic       round_last;    // round 63 now
        logic       div_done;
        logic       pad_final;     // the block being padded carries the length
    } sdb_stat_t;

    localparam logic [31:0] K_TABLE [64] = '{
        32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
        32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
        32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
        32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
        32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
        32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
        32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
        32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
        32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
        32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
        32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
    };

    localparam logic [31:0] H_INIT [8] = '{
        32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
        32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
    };

    localparam logic [7:0] PAD_MARK = 8'h80;

    function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
        rotr = (x >> n) | (x << (32 - n));
    endfunction

endpackage

/* rtl/sdb_ctrl.sv */
module sdb_ctrl
    import sdb_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  logic      byte_present,
    input  logic      end_of_message,
    output logic      m_tvalid,
    input  logic      m_tready,
    output logic [2:0] word_number,
    output sdb_cmd_t  cmd,
    input  sdb_stat_t stat
);

    sdb_state_t state_reg, state_next;
    logic       final_reg, final_next;   // compressing the final block
    logic       pad_reg, pad_next;       // padding in progress
    logic [2:0] word_reg, word_next;

    wire take = s_tvalid && s_tready;

    assign s_tready    = (state_reg == ST_IDLE);
    assign m_tvalid    = (state_reg == ST_EMIT);
    assign word_number = word_reg;

    always_comb
    begin
        state_next = state_reg;
        final_next = final_reg;
        pad_next   = pad_reg;
        word_next  = word_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (take)
                begin
                    cmd.take_byte = byte_present;
                    if (end_of_message)
                    begin
                        pad_next   = 1'b1;
                        state_next = (byte_present && stat.pos_wrap) ? ST_LOAD : ST_PAD;
                    end
                    else if (byte_present && stat.pos_wrap)
                    begin
                        state_next = ST_LOAD;
                    end
                end
            end
            ST_LOAD:
            begin
                cmd.load_work = 1'b1;
                state_next    = ST_ROUND;
            end
            ST_ROUND:
            begin
                cmd.do_round = 1'b1;
                if (stat.round_last)
                    state_next = ST_ADD;
            end
            ST_ADD:
            begin
                cmd.add_chain = 1'b1;
                if (final_reg)
                begin
                    final_next     = 1'b0;
                    pad_next       = 1'b0;
                    cmd.div_start  = 1'b1;
                    state_next     = ST_DIV;
                end
                else if (pad_reg)
                    state_next = ST_PAD;
                else
                    state_next = ST_IDLE;
            end
            ST_PAD:
            begin
                // First padding byte is the marker; later bytes are zero or length.
                cmd.pad_byte = 1'b1;
                if (stat.pos_wrap)
                begin
                    if (stat.pad_final && pad_reg)
                        final_next = 1'b1;
                    state_next = ST_LOAD;
                end
            end
            ST_DIV:
            begin
                cmd.div_step = 1'b1;
                if (stat.div_done)
                begin
                    word_next  = 3'd0;
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (m_tready)
                begin
                    cmd.emit_shift = 1'b1;
                    word_next      = word_reg + 3'd1;
                    if (word_reg == 3'd7)
                    begin
                        cmd.restart = 1'b1;
                        state_next  = ST_IDLE;
                    end
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            final_reg <= 1'b0;
            pad_reg   <= 1'b0;
            word_reg  <= 3'd0;
        end
        else
        begin
            state_reg <= state_next;
            final_reg <= final_next;
            pad_reg   <= pad_next;
            word_reg  <= word_next;
        end
    end

endmodule

/* rtl/sdb_datapath.sv */
module sdb_datapath
    import sdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic [7:0]  message_byte,
    input  logic [31:0] capacity,
    input  sdb_cmd_t    cmd,
    output sdb_stat_t   stat,
    output logic [31:0] digest_word,
    output logic [31:0] bucket_index
);

    logic [31:0] chain_reg [8];
    logic [31:0] work_reg  [8];
    logic [31:0] w_reg     [16];   // message schedule window
    logic [5:0]  pos_reg;
    logic [60:0] len_reg;
    logic [5:0]  round_reg;
    logic        marked_reg;       // marker byte already written
    logic        spill_reg;        // marker went past byte 55 in this block
    logic [31:0] rem_reg;          // running remainder
    logic [63:0] quo_reg;          // dividend shifting out
    logic [6:0]  div_cnt_reg;

    logic [63:0] bit_len;
    logic [7:0]  pad_value;
    logic [7:0]  wr_byte;
    logic [31:0] w_next_word, t1, t2;
    logic [32:0] rem_shift;
    logic [32:0] rem_diff;

    assign bit_len = {len_reg, 3'b000};

    always_comb
    begin
        if (!marked_reg)
            pad_value = PAD_MARK;
        else if (pos_reg >= 6'd56 && !spill_reg)
            pad_value = bit_len[8 * (63 - pos_reg) +: 8];
        else
            pad_value = 8'h00;
    end

    assign wr_byte = cmd.take_byte ? message_byte : pad_value;

    // The marker may land past byte 55; the length then goes in a further block.
    always_comb
    begin
        stat.pos_wrap   = (pos_reg == 6'd63);
        stat.pad_final  = marked_reg && !spill_reg;
        stat.round_last = (round_reg == 6'd63);
        stat.div_done   = (div_cnt_reg == 7'd64);
    end

    always_comb
    begin
        w_next_word = w_reg[0] + w_reg[9]
            + (rotr(w_reg[1], 7) ^ rotr(w_reg[1], 18) ^ (w_reg[1] >> 3))
            + (rotr(w_reg[14], 17) ^ rotr(w_reg[14], 19) ^ (w_reg[14] >> 10));
        t1 = work_reg[7]
            + (rotr(work_reg[4], 6) ^ rotr(work_reg[4], 11) ^ rotr(work_reg[4], 25))
            + ((work_reg[4] & work_reg[5]) ^ (~work_reg[4] & work_reg[6]))
            + K_TABLE[round_reg] + w_reg[0];
        t2 = (rotr(work_reg[0], 2) ^ rotr(work_reg[0], 13) ^ rotr(work_reg[0], 22))
            + ((work_reg[0] & work_reg[1]) ^ (work_reg[0] & work_reg[2])
               ^ (work_reg[1] & work_reg[2]));
        rem_shift = {rem_reg, quo_reg[63]};
        rem_diff  = rem_shift - {1'b0, capacity};
    end

    // Bytes shift into the schedule window in big-endian order.
    always_ff @(posedge clk)
    begin
        if (cmd.take_byte || cmd.pad_byte)
        begin
            w_reg[pos_reg[5:2]] <= {w_reg[pos_reg[5:2]][23:0], wr_byte};
        end
        else if (cmd.do_round)
        begin
            for (int i = 0; i < 15; i++)
                w_reg[i] <= w_reg[i + 1];
            w_reg[15] <= w_next_word;
        end
        if (cmd.load_work)
        begin
            for (int i = 0; i < 8; i++)
                work_reg[i] <= chain_reg[i];
        end
        else if (cmd.do_round)
        begin
            for (int i = 1; i < 8; i++)
                work_reg[i] <= work_reg[i - 1];
            work_reg[0] <= t1 + t2;
            work_reg[4] <= work_reg[3] + t1;
        end
        if (cmd.div_start)
        begin
            rem_reg <= '0;
            quo_reg <= {chain_reg[0] + work_reg[0], chain_reg[1] + work_reg[1]};
        end
        else if (cmd.div_step && div_cnt_reg != 7'd64)
        begin
            quo_reg <= {quo_reg[62:0], 1'b0};
            // The remainder stays below the capacity, so 32 bits hold it.
            if (rem_shift >= {1'b0, capacity})
                rem_reg <= rem_diff[31:0];
            else
                rem_reg <= rem_shift[31:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 8; i++)
                chain_reg[i] <= H_INIT[i];
            pos_reg     <= 6'd0;
            len_reg     <= '0;
            round_reg   <= 6'd0;
            marked_reg  <= 1'b0;
            spill_reg   <= 1'b0;
            div_cnt_reg <= 7'd0;
        end
        else
        begin
            if (cmd.take_byte)
            begin
                pos_reg <= pos_reg + 6'd1;
                len_reg <= len_reg + 61'd1;
            end
            else if (cmd.pad_byte)
            begin
                marked_reg <= 1'b1;
                pos_reg <= pos_reg + 6'd1;
                // A late marker fills its block with zeros; the next block gets the length.
                if (pos_reg == 6'd63)
                    spill_reg <= 1'b0;
                else if (!marked_reg && pos_reg >= 6'd56)
                    spill_reg <= 1'b1;
            end
            if (cmd.do_round)
                round_reg <= round_reg + 6'd1;
            if (cmd.add_chain)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= chain_reg[i] + work_reg[i];
            end
            if (cmd.div_start)
                div_cnt_reg <= 7'd0;
            else if (cmd.div_step && div_cnt_reg != 7'd64)
                div_cnt_reg <= div_cnt_reg + 7'd1;
            if (cmd.emit_shift)
            begin
                for (int i = 0; i < 7; i++)
                    chain_reg[i] <= chain_reg[i + 1];
                chain_reg[7] <= chain_reg[0];
            end
            if (cmd.restart)
            begin
                for (int i = 0; i < 8; i++)
                    chain_reg[i] <= H_INIT[i];
                pos_reg    <= 6'd0;
                len_reg    <= '0;
                marked_reg <= 1'b0;
                spill_reg  <= 1'b0;
            end
        end
    end

    assign digest_word  = chain_reg[0];
    assign bucket_index = (capacity == 32'd0) ? 32'd0 : rem_reg;

endmodule

/* rtl/sha256_digest_and_bucket_top.sv */
// Channel | Dir | tdata (low bit up)                   | tuser / tlast
// s_axis  | in  | message_byte[7:0]                    | tuser: byte_present
//         |     |                                      | tlast: end_of_message
// m_axis  | out | digest_word[31:0], word_number[34:32], | tlast: last_word
//         |     | bucket_index[66:35], pad to 72 bits  |
// cfg     | in  | cfg_wdata = bucket_capacity          | cfg_we
// Bytes are taken while idle; a full block then runs load, 64 rounds, add.
// The final item adds padding (a marker past byte 55 needs a further block),
// one or two blocks, and a restoring division for the bucket index, then
// eight output items.
// Reset restores the initial hash value; no input is taken while busy.
// Output items hold while m_tready is low.
module sha256_digest_and_bucket_top
    import sdb_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // message_byte
    input  logic        s_tuser,   // byte_present
    input  logic        s_tlast,   // end_of_message
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // digest_word, word_number, bucket_index, zero pad
    output logic        m_tlast,   // last_word
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata
);

    logic [31:0] cap_reg;
    sdb_cmd_t    cmd;
    sdb_stat_t   stat;
    logic [2:0]  word_number;
    logic [31:0] digest_word, bucket_index;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cap_reg <= CAPACITY_RESET;
        else if (cfg_we)
            cap_reg <= cfg_wdata;
    end

    sdb_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .byte_present(s_tuser), .end_of_message(s_tlast), .m_tvalid(m_tvalid),
        .m_tready(m_tready), .word_number(word_number), .cmd(cmd), .stat(stat)
    );

    sdb_datapath u_dp (
        .clk(clk), .rst_n(rst_n), .message_byte(s_tdata), .capacity(cap_reg),
        .cmd(cmd), .stat(stat), .digest_word(digest_word), .bucket_index(bucket_index)
    );

    assign m_tdata = {5'd0, bucket_index, word_number, digest_word};
    assign m_tlast = (word_number == 3'd7);

    a_no_input_busy: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready) else $error("input taken during output");
    a_one_phase: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.do_round && cmd.take_byte)) else $error("byte during round");
    a_word_step: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tready && !m_tlast) |=> m_tvalid)
        else $error("output run broken");

endmodule

/* dv/tb_sha256_digest_and_bucket_top.sv */
`timescale 1ns / 100ps

module tb_sha256_digest_and_bucket_top;
    import sdb_pkg::*;

    localparam int QUIET_LIMIT = 5000;
    localparam int SETTLE_CYCLES = 300;
    localparam int RANDOM_ITEMS = 260;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  number;
        logic [31:0] bucket;
        logic        last;
    } digest_item_t;

    class digest_scoreboard;
        logic [31:0]  chain [8];
        logic [7:0]   blk [64];
        logic [5:0]   pos;
        logic [60:0]  msg_len;
        logic [31:0]  capacity;
        digest_item_t pending_words [$];
        int           mismatches;
        int           failures;

        function new();
            capacity = CAPACITY_RESET;
            mismatches = 0;
            failures = 0;
            restart();
        endfunction

        function void restart();
            for (int i = 0; i < 8; i++)
                chain[i] = H_INIT[i];
            pos = '0;
            msg_len = '0;
        endfunction

        function logic [31:0] ror32(logic [31:0] x, int n);
            logic [63:0] both;
            both = {x, x} >> n;
            return both[31:0];
        endfunction

        function void compress();
            logic [31:0] w [64];
            logic [31:0] v [8];
            logic [31:0] t1;
            logic [31:0] t2;
            logic [31:0] s0;
            logic [31:0] s1;
            for (int i = 0; i < 16; i++)
                w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
            for (int i = 16; i < 64; i++)
            begin
                s0 = ror32(w[i-15], 7) ^ ror32(w[i-15], 18) ^ (w[i-15] >> 3);
                s1 = ror32(w[i-2], 17) ^ ror32(w[i-2], 19) ^ (w[i-2] >> 10);
                w[i] = w[i-16] + s0 + w[i-7] + s1;
            end
            for (int i = 0; i < 8; i++)
                v[i] = chain[i];
            for (int i = 0; i < 64; i++)
            begin
                t1 = v[7] + (ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25))
                     + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TABLE[i] + w[i];
                t2 = (ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22))
                     + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
                v[7] = v[6];
                v[6] = v[5];
                v[5] = v[4];
                v[4] = v[3] + t1;
                v[3] = v[2];
                v[2] = v[1];
                v[1] = v[0];
                v[0] = t1 + t2;
            end
            for (int i = 0; i < 8; i++)
                chain[i] += v[i];
        endfunction

        function void note_input(logic [7:0] data, logic present, logic last);
            int           p;
            logic [63:0]  bit_len;
            logic [63:0]  top;
            logic [31:0]  bucket;
            digest_item_t item;
            if (present)
            begin
                blk[pos] = data;
                pos = pos + 1'b1;
                msg_len = msg_len + 1'b1;
                if (pos == 0)
                    compress();
            end
            if (!last)
                return;
            blk[pos] = PAD_MARK;
            p = int'(pos) + 1;
            // Padding that does not leave room for the length spills into a second block.
            if (p > 56)
            begin
                while (p < 64)
                begin
                    blk[p] = 8'h00;
                    p++;
                end
                compress();
                p = 0;
            end
            while (p < 56)
            begin
                blk[p] = 8'h00;
                p++;
            end
            bit_len = {msg_len, 3'b000};
            for (int i = 0; i < 8; i++)
                blk[63-i] = bit_len[8*i +: 8];
            compress();
            top = {chain[0], chain[1]};
            bucket = (capacity == 0) ? 32'd0 : 32'(top % {32'd0, capacity});
            for (int i = 0; i < 8; i++)
            begin
                item.word = chain[i];
                item.number = 3'(i);
                item.bucket = bucket;
                item.last = (i == 7);
                pending_words.push_back(item);
            end
            restart();
        endfunction

        function void check_result(logic [71:0] data, logic last);
            digest_item_t want;
            if (pending_words.size() == 0)
            begin
                failures++;
                $display("ERROR: unexpected output item %h last=%0d", data, last);
                return;
            end
            want = pending_words.pop_front();
            if (data[31:0] !== want.word || data[34:32] !== want.number ||
                data[66:35] !== want.bucket || last !== want.last)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: word %h num %0d bucket %h last %0d, expected %h %0d %h %0d",
                             data[31:0], data[34:32], data[66:35], last,
                             want.word, want.number, want.bucket, want.last);
            end
        endfunction
    endclass

    logic        clk;
    logic        rst_n;
    logic        s_tvalid;
    logic        s_tready;
    logic [7:0]  s_tdata;
    logic        s_tuser;
    logic        s_tlast;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [71:0] m_tdata;
    logic        m_tlast;
    logic        cfg_we;
    logic [31:0] cfg_wdata;

    digest_scoreboard sb;
    int quiet_cycles;
    int items_sent;

    sha256_digest_and_bucket_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (r < 65)
            return 0;
        else if (r < 95)
            return $urandom_range(3, 1);
        else
            return $urandom_range(40, 10);
    endfunction

    // Receiver side: check on the handshake, then choose the next ready level.
    int stall_left;
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_result(m_tdata, m_tlast);
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready <= 1'b0;
        end
        else
        begin
            m_tready <= 1'b1;
            stall_left <= pick_gap();
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("tb_sha256_digest_and_bucket_top failed");
            $finish;
        end
    end

    task automatic send_item(input logic [7:0] data, input logic present, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= data;
        s_tuser <= present;
        s_tlast <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_input(data, present, last);
        items_sent++;
    endtask

    // A message of the given length with a few idle items mixed in. The end
    // marker either rides on the final byte or comes as an empty last item.
    task automatic send_message(input int len);
        logic empty_end;
        empty_end = (len == 0) || ($urandom_range(3) == 0);
        for (int i = 0; i < len; i++)
        begin
            if ($urandom_range(9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !empty_end && (i == len - 1));
        end
        if (empty_end)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic drain_results();
        s_tvalid <= 1'b0;
        while (sb.pending_words.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_capacity(input logic [31:0] value);
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
        cfg_we <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.capacity = value;
    endtask

    function automatic int pick_length();
        int r;
        r = $urandom_range(99);
        if (r < 55)
            return $urandom_range(12);
        else if (r < 90)
            return $urandom_range(66, 53);
        else
            return $urandom_range(130, 67);
    endfunction

    initial
    begin
        logic [31:0] caps [6];
        sb = new();
        items_sent = 0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = 8'h00;
        s_tuser = 1'b0;
        s_tlast = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = 32'd0;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: empty message, idle item, extreme bytes, both end styles.
        send_item(8'hff, 1'b0, 1'b1);
        send_item(8'h5a, 1'b0, 1'b0);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hff, 1'b1, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        write_capacity(32'd1);
        send_item(8'hff, 1'b1, 1'b1);
        write_capacity(32'hffffffff);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'h80, 1'b1, 1'b1);

        caps[0] = 32'd0;
        caps[1] = 32'd7;
        caps[2] = 32'h80000000;
        caps[3] = $urandom;
        caps[4] = 32'hffffffff;
        caps[5] = $urandom_range(1000, 2);
        items_sent = 0;
        for (int ph = 0; ph < 6; ph++)
        begin
            write_capacity(caps[ph]);
            // Padding boundary lengths come up in every phase.
            send_message(55 + (ph % 3));
            while (items_sent < (ph + 1) * RANDOM_ITEMS / 6)
            begin
                send_message(pick_length());
                if ($urandom_range(7) == 0)
                    drain_results();
            end
        end
        send_message(63);
        send_message(64);

        drain_results();
        repeat (50) @(posedge clk);
        if (sb.mismatches == 0 && sb.failures == 0 && sb.pending_words.size() == 0)
            $display("tb_sha256_digest_and_bucket_top passed");
        else
            $display("tb_sha256_digest_and_bucket_top failed");
        $finish;
    end

endmodule
